@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker RTL.
// Each use expects clk and rst_n in scope and ends its own statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KV_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kv checker: property violated");
`define KV_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("kv checker: forbidden condition seen");
`else
`define KV_ASSERT(lbl, prop)
`define KV_NEVER(lbl, cond)
`endif
`endif

@@ rtl/kvmsc_pkg.sv @@
// ----------------------------------------------------------------------------
// kvmsc_pkg
// Shared types, codes and helpers of the key-value metadata stream checker.
// ----------------------------------------------------------------------------
package kvmsc_pkg;

    // Any declared count or length above 2^REGION_BITS-1 is out of bound.
    localparam int REGION_BITS = 28;
    localparam int SEEN_W      = 28;

    localparam logic [2:0] FAULT_NONE      = 3'd0;
    localparam logic [2:0] FAULT_TRUNC     = 3'd1;
    localparam logic [2:0] FAULT_BAD_TYPE  = 3'd2;
    localparam logic [2:0] FAULT_NESTED    = 3'd3;
    localparam logic [2:0] FAULT_BAD_ELEM  = 3'd4;
    localparam logic [2:0] FAULT_OVER      = 3'd5;

    localparam logic [31:0] TYPE_STRING = 32'd8;
    localparam logic [31:0] TYPE_ARRAY  = 32'd9;

    // One byte of the region as it waits between intake and walker.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } q_item_t;

    typedef struct packed {
        logic       ok;   // a fixed-size scalar type
        logic [1:0] lg;   // log2 of its size in bytes
    } scalar_info_t;

    function automatic scalar_info_t scalar_info(input logic [31:0] t);
        scalar_info_t r;
        r = '{ok: 1'b1, lg: 2'd0};
        case (t)
            32'd0, 32'd1, 32'd7: r.lg = 2'd0;
            32'd2, 32'd3:        r.lg = 2'd1;
            32'd4, 32'd5, 32'd6: r.lg = 2'd2;
            32'd10, 32'd11, 32'd12: r.lg = 2'd3;
            default: r.ok = 1'b0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/kv_metadata_stream_checker.sv @@
// ----------------------------------------------------------------------------
// kv_metadata_stream_checker
// Byte-serial validator of a little-endian key-value metadata region.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   in        in_valid/in_stall    data_byte[7:0], last_byte
//   out       out_valid/out_stall  region_ok, fault_code[2:0], entries_seen[27:0]
//
// One byte per cycle sustained while the output is not stalled; every byte is a
// fixed counter/compare step in the walker. A verdict is registered once its
// last byte leaves the intake queue. The intake holds bytes in a two-entry
// queue, so it keeps taking bytes while a verdict waits at the output; only a
// last byte waits for the output slot. Reset is immediate: no clearing pass.
// ----------------------------------------------------------------------------
module kv_metadata_stream_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   data_byte,
    input  logic                         last_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         region_ok,
    output logic [2:0]                   fault_code,
    output logic [kvmsc_pkg::SEEN_W-1:0] entries_seen
);
    import kvmsc_pkg::*;

    q_item_t head;
    logic    head_valid;
    logic    pop;

    kvmsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    kvmsc_walker u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .region_ok    (region_ok),
        .fault_code   (fault_code),
        .entries_seen (entries_seen)
    );

endmodule

@@ rtl/kvmsc_front.sv @@
// ----------------------------------------------------------------------------
// kvmsc_front
// Intake side: takes region bytes and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kvmsc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output kvmsc_pkg::q_item_t head,
    output logic               head_valid,
    input  logic               pop
);
    import kvmsc_pkg::*;

    q_item_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;

    assign in_stall   = (cnt_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (cnt_reg != 2'd0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{data: data_byte, last: last_byte};
        end
    end

    `KV_NEVER(a_q_overfill, cnt_reg == 2'd3)
    `KV_NEVER(a_q_pop_empty, pop && (cnt_reg == 2'd0))
    `KV_ASSERT(a_q_ptr_gap, (wr_ptr_reg ^ rd_ptr_reg) == cnt_reg[0])

endmodule

@@ rtl/kvmsc_walker.sv @@
// ----------------------------------------------------------------------------
// kvmsc_walker
// Back side: walks the entry structure one byte per cycle while the output
// is not stalled, and registers the verdict on the last byte of each region.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kvmsc_walker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  kvmsc_pkg::q_item_t               head,
    input  logic                             head_valid,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             region_ok,
    output logic [2:0]                       fault_code,
    output logic [kvmsc_pkg::SEEN_W-1:0]     entries_seen
);
    import kvmsc_pkg::*;

    localparam int RB = REGION_BITS;

    typedef enum logic [9:0] {
        PH_COUNT    = 10'b0000000001,
        PH_KEYLEN   = 10'b0000000010,
        PH_KEYBODY  = 10'b0000000100,
        PH_TYPE     = 10'b0000001000,
        PH_VALBYTES = 10'b0000010000,
        PH_STRLEN   = 10'b0000100000,
        PH_ETYPE    = 10'b0001000000,
        PH_ACOUNT   = 10'b0010000000,
        PH_ELEN     = 10'b0100000000,
        PH_EBODY    = 10'b1000000000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [2:0]        idx_reg, idx_next;
    logic [55:0]       shift_reg, shift_next;
    logic [RB-1:0]     ent_left_reg, ent_left_next;
    logic [RB-1:0]     run_left_reg, run_left_next;
    logic [RB-1:0]     str_left_reg, str_left_next;
    logic [3:0]        etype_reg, etype_next;
    logic [2:0]        fault_reg, fault_next;
    logic              fin_reg, fin_next;
    logic [SEEN_W-1:0] count_reg, count_next;

    logic              out_valid_reg, out_valid_next;
    logic              region_ok_reg;
    logic [2:0]        fault_code_reg;
    logic [SEEN_W-1:0] entries_seen_reg;

    logic              take;
    logic              verdict;
    logic              gather_en, gather4, gather_done;
    logic [63:0]       v64;
    logic [31:0]       v32;
    logic              v_over, v_zero, arr_over;
    logic [RB-1:0]     arr_bytes;
    scalar_info_t      type_info, elem_info;
    logic              str_done, ent_done;

    // A non-last byte never waits on the output register.
    assign take    = head_valid && (!head.last || !out_valid_reg || !out_stall);
    assign pop     = take;
    assign verdict = take && head.last;

    assign v64       = {head.data, shift_reg};
    assign v32       = {head.data, shift_reg[23:0]};
    assign v_over    = |v64[63:RB];
    assign v_zero    = (v64 == 64'd0);
    assign type_info = scalar_info(v32);
    assign elem_info = scalar_info({28'd0, etype_reg});
    assign arr_bytes = v64[RB-1:0] << elem_info.lg;

    // Array byte size stays in bound when count fits in RB - log2(size) bits.
    always_comb
    begin
        case (elem_info.lg)
            2'd0:    arr_over = |v64[63:RB];
            2'd1:    arr_over = |v64[63:RB-1];
            2'd2:    arr_over = |v64[63:RB-2];
            2'd3:    arr_over = |v64[63:RB-3];
            default: arr_over = 1'b1;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        shift_next    = shift_reg;
        ent_left_next = ent_left_reg;
        run_left_next = run_left_reg;
        str_left_next = str_left_reg;
        etype_next    = etype_reg;
        fault_next    = fault_reg;
        fin_next      = fin_reg;
        count_next    = count_reg;
        gather_en     = 1'b0;
        gather4       = 1'b0;
        gather_done   = 1'b0;
        str_done      = 1'b0;
        ent_done      = 1'b0;

        if (take && (fault_reg == FAULT_NONE) && !fin_reg)
        begin
            case (phase_reg)
                PH_COUNT:
                begin
                    gather_en = 1'b1;
                    if (idx_reg == 3'd7)
                    begin
                        if (v_over)
                        begin
                            fault_next = FAULT_OVER;
                        end
                        else
                        begin
                            ent_left_next = v64[RB-1:0];
                            if (v_zero)
                            begin
                                fin_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_KEYLEN;
                            end
                        end
                    end
                end
                PH_KEYLEN:
                begin
                    gather_en = 1'b1;
                    if (idx_reg == 3'd7)
                    begin
                        if (v_over)
                        begin
                            fault_next = FAULT_OVER;
                        end
                        else
                        begin
                            run_left_next = v64[RB-1:0];
                            phase_next    = v_zero ? PH_TYPE : PH_KEYBODY;
                        end
                    end
                end
                PH_KEYBODY:
                begin
                    run_left_next = run_left_reg - 1'b1;
                    if (run_left_reg == RB'(1))
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    gather_en = 1'b1;
                    gather4   = 1'b1;
                    if (idx_reg == 3'd3)
                    begin
                        if (type_info.ok)
                        begin
                            run_left_next = {{(RB-4){1'b0}}, 4'd1 << type_info.lg};
                            phase_next    = PH_VALBYTES;
                        end
                        else if (v32 == TYPE_STRING)
                        begin
                            phase_next = PH_STRLEN;
                        end
                        else if (v32 == TYPE_ARRAY)
                        begin
                            phase_next = PH_ETYPE;
                        end
                        else
                        begin
                            fault_next = FAULT_BAD_TYPE;
                        end
                    end
                end
                PH_VALBYTES:
                begin
                    run_left_next = run_left_reg - 1'b1;
                    if (run_left_reg == RB'(1))
                    begin
                        ent_done = 1'b1;
                    end
                end
                PH_STRLEN:
                begin
                    gather_en = 1'b1;
                    if (idx_reg == 3'd7)
                    begin
                        if (v_over)
                        begin
                            fault_next = FAULT_OVER;
                        end
                        else if (v_zero)
                        begin
                            ent_done = 1'b1;
                        end
                        else
                        begin
                            run_left_next = v64[RB-1:0];
                            phase_next    = PH_VALBYTES;
                        end
                    end
                end
                PH_ETYPE:
                begin
                    gather_en = 1'b1;
                    gather4   = 1'b1;
                    if (idx_reg == 3'd3)
                    begin
                        if (v32 == TYPE_ARRAY)
                        begin
                            fault_next = FAULT_NESTED;
                        end
                        else if ((v32 != TYPE_STRING) && !type_info.ok)
                        begin
                            fault_next = FAULT_BAD_ELEM;
                        end
                        else
                        begin
                            etype_next = v32[3:0];
                            phase_next = PH_ACOUNT;
                        end
                    end
                end
                PH_ACOUNT:
                begin
                    gather_en = 1'b1;
                    if (idx_reg == 3'd7)
                    begin
                        if ({28'd0, etype_reg} == TYPE_STRING)
                        begin
                            if (v_over)
                            begin
                                fault_next = FAULT_OVER;
                            end
                            else
                            begin
                                str_left_next = v64[RB-1:0];
                                if (v_zero)
                                begin
                                    ent_done = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_ELEN;
                                end
                            end
                        end
                        else if (!elem_info.ok || arr_over)
                        begin
                            fault_next = FAULT_OVER;
                        end
                        else if (v_zero)
                        begin
                            ent_done = 1'b1;
                        end
                        else
                        begin
                            run_left_next = arr_bytes;
                            phase_next    = PH_VALBYTES;
                        end
                    end
                end
                PH_ELEN:
                begin
                    gather_en = 1'b1;
                    if (idx_reg == 3'd7)
                    begin
                        if (v_over)
                        begin
                            fault_next = FAULT_OVER;
                        end
                        else if (v_zero)
                        begin
                            str_done = 1'b1;
                        end
                        else
                        begin
                            run_left_next = v64[RB-1:0];
                            phase_next    = PH_EBODY;
                        end
                    end
                end
                PH_EBODY:
                begin
                    run_left_next = run_left_reg - 1'b1;
                    if (run_left_reg == RB'(1))
                    begin
                        str_done = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_COUNT;
                end
            endcase
        end

        // Gather little-endian field bytes; restart the index once complete.
        if (gather_en)
        begin
            gather_done = gather4 ? (idx_reg == 3'd3) : (idx_reg == 3'd7);
            if (gather_done)
            begin
                idx_next = 3'd0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
                shift_next[{idx_reg, 3'b000} +: 8] = head.data;
            end
        end

        if (str_done)
        begin
            str_left_next = str_left_reg - 1'b1;
            if (str_left_reg == RB'(1))
            begin
                ent_done = 1'b1;
            end
            else
            begin
                phase_next = PH_ELEN;
            end
        end

        if (ent_done)
        begin
            if (count_reg != '1)
            begin
                count_next = count_reg + 1'b1;
            end
            ent_left_next = ent_left_reg - 1'b1;
            if (ent_left_reg == RB'(1))
            begin
                fin_next = 1'b1;
            end
            else
            begin
                phase_next = PH_KEYLEN;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (verdict)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_COUNT;
            idx_reg       <= 3'd0;
            ent_left_reg  <= '0;
            run_left_reg  <= '0;
            str_left_reg  <= '0;
            etype_reg     <= 4'd0;
            fault_reg     <= FAULT_NONE;
            fin_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (verdict)
        begin
            // Re-arm for the next region.
            phase_reg     <= PH_COUNT;
            idx_reg       <= 3'd0;
            ent_left_reg  <= '0;
            run_left_reg  <= '0;
            str_left_reg  <= '0;
            etype_reg     <= 4'd0;
            fault_reg     <= FAULT_NONE;
            fin_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= out_valid_next;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            ent_left_reg  <= ent_left_next;
            run_left_reg  <= run_left_next;
            str_left_reg  <= str_left_next;
            etype_reg     <= etype_next;
            fault_reg     <= fault_next;
            fin_reg       <= fin_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        if (verdict)
        begin
            entries_seen_reg <= count_next;
            if (fault_next != FAULT_NONE)
            begin
                region_ok_reg  <= 1'b0;
                fault_code_reg <= fault_next;
            end
            else if (fin_next)
            begin
                region_ok_reg  <= 1'b1;
                fault_code_reg <= FAULT_NONE;
            end
            else
            begin
                region_ok_reg  <= 1'b0;
                fault_code_reg <= FAULT_TRUNC;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign region_ok    = region_ok_reg;
    assign fault_code   = fault_code_reg;
    assign entries_seen = entries_seen_reg;

    `KV_ASSERT(a_w_fault_freezes, ((fault_reg != FAULT_NONE) && !verdict) |=> $stable(phase_reg))
    `KV_ASSERT(a_w_verdict_code, out_valid_reg |-> (region_ok_reg == (fault_code_reg == FAULT_NONE)))
    `KV_NEVER(a_w_fault_and_done, (fault_reg != FAULT_NONE) && fin_reg)

endmodule

@@ sim/tb_kv_metadata_stream_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kv_metadata_stream_checker
// Feeds byte-serial key-value metadata regions, both well-formed and corrupted
// (truncation, bad types, nested arrays, over-bound lengths, trailing bytes,
// noise), into the checker and compares each verdict against a cycle-free
// model of the region walker.
// ----------------------------------------------------------------------------
module tb_kv_metadata_stream_checker;
    import kvmsc_pkg::*;

    localparam logic [63:0] LEN_BOUND = (64'd1 << REGION_BITS) - 64'd1;

    typedef enum logic [3:0] {
        W_COUNT, W_KEYLEN, W_KEYBODY, W_TYPE, W_VALUE,
        W_STRLEN, W_ETYPE, W_ACOUNT, W_ELEN, W_EBODY
    } walk_phase_e;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } region_byte_t;

    typedef struct {
        logic              ok;
        logic [2:0]        code;
        logic [SEEN_W-1:0] seen;
    } verdict_t;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] data_byte = 8'd0;
    logic last_byte = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic region_ok;
    logic [2:0] fault_code;
    logic [SEEN_W-1:0] entries_seen;

    region_byte_t region_bytes[$];
    verdict_t     verdicts_due[$];
    int           bytes_sent = 0;
    int           mismatches = 0;
    int           hold_left = 0;
    logic         hold_armed = 1'b1;
    int           send_gap_pct;
    int           recv_stall_pct;

    // walker model state
    walk_phase_e       walk_phase;
    int                fld_idx;
    logic [63:0]       fld_acc;
    logic [63:0]       fld_word;
    logic [63:0]       ents_left;
    logic [63:0]       run_left;
    logic [63:0]       strs_left;
    logic [31:0]       elem_kind;
    logic [2:0]        walk_fault;
    logic              walk_done;
    logic [SEEN_W-1:0] ents_parsed;

    kv_metadata_stream_checker i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .region_ok    (region_ok),
        .fault_code   (fault_code),
        .entries_seen (entries_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[kv_metadata_stream_checker] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Walker model
    // ------------------------------------------------------------------------
    function automatic int scalar_bytes(input logic [63:0] t);
        case (t)
            64'd0, 64'd1, 64'd7:    return 1;
            64'd2, 64'd3:           return 2;
            64'd4, 64'd5, 64'd6:    return 4;
            64'd10, 64'd11, 64'd12: return 8;
            default:                return 0;
        endcase
    endfunction

    function automatic void walker_clear();
        walk_phase  = W_COUNT;
        fld_idx     = 0;
        fld_acc     = '0;
        fld_word    = '0;
        ents_left   = '0;
        run_left    = '0;
        strs_left   = '0;
        elem_kind   = '0;
        walk_fault  = FAULT_NONE;
        walk_done   = 1'b0;
        ents_parsed = '0;
    endfunction

    // Collect one little-endian field; the finished value lands in fld_word.
    function automatic bit field_in(input logic [7:0] b, input int nbytes);
        fld_acc[8*fld_idx +: 8] = b;
        fld_idx = fld_idx + 1;
        if (fld_idx == nbytes)
        begin
            fld_word = fld_acc;
            fld_acc  = '0;
            fld_idx  = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void entry_finished();
        if (ents_parsed != '1)
            ents_parsed = ents_parsed + 1'b1;
        if (ents_left != 0)
            ents_left = ents_left - 1;
        if (ents_left == 0)
            walk_done = 1'b1;
        else
            walk_phase = W_KEYLEN;
    endfunction

    function automatic void string_finished();
        if (strs_left != 0)
            strs_left = strs_left - 1;
        if (strs_left == 0)
            entry_finished();
        else
            walk_phase = W_ELEN;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        logic [63:0] v;
        logic [63:0] sz;
        case (walk_phase)
            W_COUNT:
                if (field_in(b, 8))
                begin
                    v = fld_word;
                    if (v > LEN_BOUND)
                        walk_fault = FAULT_OVER;
                    else
                    begin
                        ents_left = v;
                        if (v == 0)
                            walk_done = 1'b1;
                        else
                            walk_phase = W_KEYLEN;
                    end
                end
            W_KEYLEN:
                if (field_in(b, 8))
                begin
                    v = fld_word;
                    if (v > LEN_BOUND)
                        walk_fault = FAULT_OVER;
                    else
                    begin
                        run_left   = v;
                        walk_phase = (v == 0) ? W_TYPE : W_KEYBODY;
                    end
                end
            W_KEYBODY:
            begin
                run_left = run_left - 1;
                if (run_left == 0)
                    walk_phase = W_TYPE;
            end
            W_TYPE:
                if (field_in(b, 4))
                begin
                    v  = fld_word;
                    sz = scalar_bytes(v);
                    if (sz != 0)
                    begin
                        run_left   = sz;
                        walk_phase = W_VALUE;
                    end
                    else if (v == TYPE_STRING)
                        walk_phase = W_STRLEN;
                    else if (v == TYPE_ARRAY)
                        walk_phase = W_ETYPE;
                    else
                        walk_fault = FAULT_BAD_TYPE;
                end
            W_VALUE:
            begin
                run_left = run_left - 1;
                if (run_left == 0)
                    entry_finished();
            end
            W_STRLEN:
                if (field_in(b, 8))
                begin
                    v = fld_word;
                    if (v > LEN_BOUND)
                        walk_fault = FAULT_OVER;
                    else if (v == 0)
                        entry_finished();
                    else
                    begin
                        run_left   = v;
                        walk_phase = W_VALUE;
                    end
                end
            W_ETYPE:
                if (field_in(b, 4))
                begin
                    v = fld_word;
                    if (v == TYPE_ARRAY)
                        walk_fault = FAULT_NESTED;
                    else if (v != TYPE_STRING && scalar_bytes(v) == 0)
                        walk_fault = FAULT_BAD_ELEM;
                    else
                    begin
                        elem_kind  = v[31:0];
                        walk_phase = W_ACOUNT;
                    end
                end
            W_ACOUNT:
                if (field_in(b, 8))
                begin
                    v = fld_word;
                    if (elem_kind == TYPE_STRING)
                    begin
                        if (v > LEN_BOUND)
                            walk_fault = FAULT_OVER;
                        else
                        begin
                            strs_left = v;
                            if (v == 0)
                                entry_finished();
                            else
                                walk_phase = W_ELEN;
                        end
                    end
                    else
                    begin
                        sz = scalar_bytes(elem_kind);
                        // total byte size of the array must stay within bound
                        if (sz == 0 || v > LEN_BOUND / sz)
                            walk_fault = FAULT_OVER;
                        else if (v == 0)
                            entry_finished();
                        else
                        begin
                            run_left   = v * sz;
                            walk_phase = W_VALUE;
                        end
                    end
                end
            W_ELEN:
                if (field_in(b, 8))
                begin
                    v = fld_word;
                    if (v > LEN_BOUND)
                        walk_fault = FAULT_OVER;
                    else if (v == 0)
                        string_finished();
                    else
                    begin
                        run_left   = v;
                        walk_phase = W_EBODY;
                    end
                end
            W_EBODY:
            begin
                run_left = run_left - 1;
                if (run_left == 0)
                    string_finished();
            end
            default:
                walk_phase = W_COUNT;
        endcase
    endfunction

    function automatic void predict_transfer(input logic [7:0] b, input logic fin);
        verdict_t want;
        // first fault wins; bytes after a finished walk are trailing
        if (walk_fault == FAULT_NONE && !walk_done)
            absorb_byte(b);
        if (fin)
        begin
            if (walk_fault != FAULT_NONE)
                want = '{ok: 1'b0, code: walk_fault, seen: ents_parsed};
            else if (walk_done)
                want = '{ok: 1'b1, code: FAULT_NONE, seen: ents_parsed};
            else
                want = '{ok: 1'b0, code: FAULT_TRUNC, seen: ents_parsed};
            verdicts_due.push_back(want);
            walker_clear();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Region builder
    // ------------------------------------------------------------------------
    task automatic push_field(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            region_bytes.push_back('{data: v[8*i +: 8], last: 1'b0});
    endtask

    task automatic push_junk(input int n);
        for (int i = 0; i < n; i++)
            region_bytes.push_back('{data: 8'($urandom), last: 1'b0});
    endtask

    task automatic close_region();
        region_bytes[region_bytes.size()-1].last = 1'b1;
    endtask

    function automatic logic [63:0] big_len();
        logic [63:0] v;
        case ($urandom_range(0, 3))
            0: v = LEN_BOUND + 64'd1;
            1: v = '1;
            2:
            begin
                v = {$urandom, $urandom};
                v[REGION_BITS] = 1'b1;
            end
            default: v = LEN_BOUND;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] bad_type();
        case ($urandom_range(0, 2))
            0:       return 32'd13 + $urandom_range(0, 40);
            1:       return 32'hFFFF_FFFF;
            default: return $urandom | 32'h10;
        endcase
    endfunction

    function automatic logic [31:0] pick_scalar();
        int t;
        t = $urandom_range(0, 10);
        if (t >= 8)
            t = t + 2;
        return 32'(t);
    endfunction

    // flaw: 0 none, 1 key length at/over bound, 2 bad type, 3 nested array,
    // 4 bad element type, 5 string length at/over bound, 6 array count at/over bound
    task automatic push_entry(input int flaw);
        int          klen;
        int          kind;
        int          cnt;
        int          len;
        int          sz;
        logic [31:0] t;
        klen = $urandom_range(0, 4);
        if (flaw == 1)
        begin
            push_field(big_len(), 8);
            push_junk($urandom_range(0, 6));
            return;
        end
        push_field(64'(klen), 8);
        push_junk(klen);
        if (flaw == 2)
        begin
            push_field(64'(bad_type()), 4);
            push_junk($urandom_range(0, 6));
            return;
        end
        kind = $urandom_range(0, 2);
        if (flaw == 5)
            kind = 1;
        else if (flaw >= 3)
            kind = 2;
        if (kind == 0)
        begin
            t = pick_scalar();
            push_field(64'(t), 4);
            push_junk(scalar_bytes(64'(t)));
        end
        else if (kind == 1)
        begin
            push_field(64'(TYPE_STRING), 4);
            if (flaw == 5)
            begin
                push_field(big_len(), 8);
                push_junk($urandom_range(0, 6));
                return;
            end
            len = $urandom_range(0, 5);
            push_field(64'(len), 8);
            push_junk(len);
        end
        else
        begin
            push_field(64'(TYPE_ARRAY), 4);
            if (flaw == 3 || flaw == 4)
            begin
                push_field(64'((flaw == 3) ? TYPE_ARRAY : bad_type()), 4);
                push_junk($urandom_range(0, 6));
                return;
            end
            if ($urandom_range(0, 1) == 0)
            begin
                push_field(64'(TYPE_STRING), 4);
                if (flaw == 6)
                begin
                    push_field(big_len(), 8);
                    push_junk($urandom_range(0, 6));
                    return;
                end
                cnt = $urandom_range(0, 3);
                push_field(64'(cnt), 8);
                for (int i = 0; i < cnt; i++)
                begin
                    len = $urandom_range(0, 3);
                    push_field(64'(len), 8);
                    push_junk(len);
                end
            end
            else
            begin
                t  = pick_scalar();
                sz = scalar_bytes(64'(t));
                push_field(64'(t), 4);
                if (flaw == 6)
                begin
                    push_field(LEN_BOUND / sz + 64'd1 + $urandom_range(0, 3), 8);
                    push_junk($urandom_range(0, 6));
                    return;
                end
                cnt = $urandom_range(0, 4);
                push_field(64'(cnt), 8);
                push_junk(cnt * sz);
            end
        end
    endtask

    // mode: 0..5 clean, 6 cut short, 7 flawed entry, 8 trailing bytes,
    // 9 count above entries present, 10 count at/over bound, 11 noise
    task automatic build_region();
        int start;
        int mode;
        int n_ent;
        int bad_at;
        int cut;
        start = region_bytes.size();
        mode  = $urandom_range(0, 11);
        if (mode == 11)
            push_junk($urandom_range(1, 12));
        else if (mode == 10)
        begin
            push_field(big_len(), 8);
            push_junk($urandom_range(0, 3));
        end
        else
        begin
            n_ent  = $urandom_range((mode == 6 || mode == 7) ? 1 : 0, 3);
            bad_at = (mode == 7) ? $urandom_range(0, n_ent - 1) : -1;
            push_field(64'(n_ent + ((mode == 9) ? $urandom_range(1, 3) : 0)), 8);
            for (int e = 0; e < n_ent; e++)
                push_entry((e == bad_at) ? $urandom_range(1, 6) : 0);
            if (mode == 8)
                push_junk($urandom_range(1, 4));
            if (mode == 6 && region_bytes.size() - start > 1)
            begin
                cut = $urandom_range(1, region_bytes.size() - start - 1);
                repeat (cut)
                    void'(region_bytes.pop_back());
            end
        end
        close_region();
    endtask

    // ------------------------------------------------------------------------
    // Idle pattern, sender and receiver
    // ------------------------------------------------------------------------
    always_comb
    begin
        case ((bytes_sent / 100) % 4)
            0:
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_gap_pct   = 50;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 50;
            end
            default:
            begin
                send_gap_pct   = 36;
                recv_stall_pct = 36;
            end
        endcase
    end

    // Hold off the receiver once for a long stretch so the intake fills.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && bytes_sent >= 450)
        begin
            hold_left  <= 300;
            hold_armed <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            data_byte  <= 8'd0;
            last_byte  <= 1'b0;
            bytes_sent <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                predict_transfer(data_byte, last_byte);
                bytes_sent <= bytes_sent + 1;
            end
            if (region_bytes.size() != 0
                && (hold_left != 0 || $urandom_range(0, 99) >= send_gap_pct))
            begin
                in_valid  <= 1'b1;
                data_byte <= region_bytes[0].data;
                last_byte <= region_bytes[0].last;
                region_bytes.delete(0);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : verdict_watch
        verdict_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: verdict with none expected: ok %0d fault %0d seen %0d",
                             $time, region_ok, fault_code, entries_seen);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (region_ok !== want.ok)
                    begin
                        mismatches++;
                        $display("%0t: region_ok expected %0d got %0d",
                                 $time, want.ok, region_ok);
                    end
                    if (fault_code !== want.code)
                    begin
                        mismatches++;
                        $display("%0t: fault_code expected %0d got %0d",
                                 $time, want.code, fault_code);
                    end
                    if (entries_seen !== want.seen)
                    begin
                        mismatches++;
                        $display("%0t: entries_seen expected %0d got %0d",
                                 $time, want.seen, entries_seen);
                    end
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int regions;
        walker_clear();

        // empty region with one trailing byte
        push_field(64'd0, 8);
        push_field(64'hFF, 1);
        close_region();
        // entry count far over bound
        push_field(64'hFF00_0000_0000_0000, 8);
        close_region();
        // region that ends on its first byte
        push_field(64'h00, 1);
        close_region();

        regions = 3;
        while (region_bytes.size() < 1200 || regions < 20)
        begin
            build_region();
            regions++;
        end

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (region_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("[kv_metadata_stream_checker] OK");
        else
            $display("[kv_metadata_stream_checker] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/kvmsc_pkg.sv
rtl/kvmsc_front.sv
rtl/kvmsc_walker.sv
rtl/kv_metadata_stream_checker.sv
sim/tb_kv_metadata_stream_checker.sv
